/* sv/boot_info_framebuffer_tag_scan_macros.svh */
// Assertion helpers shared by the tag scanner RTL.
`ifndef BOOT_INFO_FRAMEBUFFER_TAG_SCAN_MACROS_SVH
`define BOOT_INFO_FRAMEBUFFER_TAG_SCAN_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BIFTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bifts: implication check failed");

// Next-cycle implication, checked outside reset.
`define BIFTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bifts: next-cycle check failed");

`endif

/* sv/bifts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bifts_pkg;

	typedef enum logic [1:0] {
		ST_ACCEPT  = 2'd0,
		ST_END     = 2'd1,
		ST_EXHAUST = 2'd2,
		ST_WRAP    = 2'd3
	} status_t;

	localparam logic [31:0] FB_TAG_TYPE   = 32'd8;
	localparam logic [31:0] FB_TAG_MIN    = 32'd32;
	localparam logic [31:0] END_TAG_TYPE  = 32'd0;
	localparam logic [31:0] FIRST_TAG_OFF = 32'd8;
	localparam logic [31:0] MIN_TOTAL     = 32'd16;
	localparam logic [7:0]  WANT_BPP      = 8'd32;
	localparam logic [7:0]  WANT_KIND     = 8'd1;

	// Byte offsets of header and framebuffer fields within a tag
	localparam logic [31:0] REL_KIND   = 32'd0;
	localparam logic [31:0] REL_SIZE   = 32'd4;
	localparam logic [31:0] REL_ADDR_L = 32'd8;
	localparam logic [31:0] REL_ADDR_H = 32'd12;
	localparam logic [31:0] REL_PITCH  = 32'd16;
	localparam logic [31:0] REL_WIDTH  = 32'd20;
	localparam logic [31:0] REL_HEIGHT = 32'd24;
	localparam logic [31:0] REL_FORMAT = 32'd28;

	typedef struct packed {
		status_t     status;
		logic [63:0] fb_addr;
		logic [31:0] fb_pitch;
		logic [31:0] fb_width;
		logic [31:0] fb_height;
		logic [7:0]  fb_bpp;
		logic [7:0]  fb_kind;
	} result_t;

endpackage

`default_nettype wire

/* sv/bifts_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface bifts_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] word;
	logic        first_word;

	modport source (output valid, output word, output first_word, input ready);
	modport sink (input valid, input word, input first_word, output ready);
endinterface

interface bifts_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] fb_addr;
	logic [31:0] fb_pitch;
	logic [31:0] fb_width;
	logic [31:0] fb_height;
	logic [7:0]  fb_bpp;
	logic [7:0]  fb_kind;

	modport source (output valid, output status, output fb_addr, output fb_pitch,
		output fb_width, output fb_height, output fb_bpp, output fb_kind, input ready);
	modport sink (input valid, input status, input fb_addr, input fb_pitch,
		input fb_width, input fb_height, input fb_bpp, input fb_kind, output ready);
endinterface

`default_nettype wire

/* sv/boot_info_framebuffer_tag_scan.sv */
// Framebuffer tag scanner for a multiboot2-style boot information structure.
// ingress (sink): one 32-bit word per handshake, in address order; first_word
//   marks the total-size word and restarts the scan, clearing captures.
// egress (source): one result word per scan: status (accepted, end tag, size
//   exhausted, offset wrapped) plus the last captured framebuffer fields.
// Throughput: one word per cycle while egress is not stalled. Every word does
//   a compare, a round-up and one 34-bit add/compare against the total size,
//   all combinational between the input register and the walk state.
// Path: an accepted word is held in the input register and its result is
//   kept in the output register (two register stages: input word, output result).
// After the result, words are dropped until the next first_word.
// Reset: scan is idle (words ignored until first_word), egress empty.
// Stall: while a result waits and egress.ready is low, the input register
//   holds; ingress.ready stays high only while that register is empty, so
//   at most one more word is taken during a stall.
`timescale 1ns / 1ps
`default_nettype none
`include "boot_info_framebuffer_tag_scan_macros.svh"

module boot_info_framebuffer_tag_scan
	import bifts_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	bifts_in_if.sink    ingress,
	bifts_out_if.source egress
);

	// input register stage
	logic        valid_s1;
	logic [31:0] word_s1;
	logic        first_s1;

	// output register
	logic        out_valid_q;
	result_t     out_res_q;

	logic        out_free;
	logic        fire;
	logic        res_valid;
	result_t     res;

	// the walk may step only if a result it makes has somewhere to go
	assign out_free      = !out_valid_q || egress.ready;
	assign fire          = valid_s1 && out_free;
	assign ingress.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ingress.ready) begin
			valid_s1 <= ingress.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ingress.ready && ingress.valid) begin
			word_s1  <= ingress.word;
			first_s1 <= ingress.first_word;
		end
	end

	bifts_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.word       (word_s1),
		.first_word (first_s1),
		.res_valid  (res_valid),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (egress.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			out_res_q <= res;
		end
	end

	assign egress.valid     = out_valid_q;
	assign egress.status    = out_res_q.status;
	assign egress.fb_addr   = out_res_q.fb_addr;
	assign egress.fb_pitch  = out_res_q.fb_pitch;
	assign egress.fb_width  = out_res_q.fb_width;
	assign egress.fb_height = out_res_q.fb_height;
	assign egress.fb_bpp    = out_res_q.fb_bpp;
	assign egress.fb_kind   = out_res_q.fb_kind;

	// a stalled input word must not be lost or changed
	`BIFTS_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !out_free, valid_s1 && $stable(word_s1) && $stable(first_s1))
	// a result produced by the walk shows up on egress next cycle
	`BIFTS_ASSERT_NEXT(a_res_out, clk, arst_n, fire && res_valid, out_valid_q && (out_res_q.status == $past(res.status)))
	// an accepted framebuffer always meets the format rules
	`BIFTS_ASSERT_IMPLY(a_accept_fmt, clk, arst_n, out_valid_q && (out_res_q.status == ST_ACCEPT), (out_res_q.fb_bpp == WANT_BPP) && (out_res_q.fb_kind == WANT_KIND) && (out_res_q.fb_addr != 64'd0))

endmodule

`default_nettype wire

/* sv/bifts_walk.sv */
`timescale 1ns / 1ps
`default_nettype none

module bifts_walk
	import bifts_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  wire logic [31:0] word,
	input  wire logic        first_word,
	output logic             res_valid,
	output result_t          res
);

	logic [31:0] byte_pos_q, byte_pos_d;
	logic [31:0] total_q, total_d;
	logic [31:0] tag_base_q, tag_base_d;
	logic [31:0] tag_kind_q, tag_kind_d;
	logic [31:0] tag_bytes_q, tag_bytes_d;
	logic [63:0] cap_addr_q, cap_addr_d;
	logic [31:0] cap_pitch_q, cap_pitch_d;
	logic [31:0] cap_width_q, cap_width_d;
	logic [31:0] cap_height_q, cap_height_d;
	logic [7:0]  cap_bpp_q, cap_bpp_d;
	logic [7:0]  cap_kind_q, cap_kind_d;
	logic        scan_over_q, scan_over_d;

	logic [31:0] rel;
	logic        capturing;
	logic [31:0] size_sel;
	logic [32:0] rnd;
	logic [31:0] adv;
	logic [32:0] next_off;
	logic [33:0] next_end;
	logic        adv_wrap, adv_exh;
	logic        do_adv;
	logic        fmt_ok;

	// Next-tag arithmetic: round size up to a multiple of 8, at least 8, then range checks; also capture and format tests
	always_comb begin
		rel       = byte_pos_q - tag_base_q;
		capturing = (tag_kind_q == FB_TAG_TYPE) && (tag_bytes_q >= FB_TAG_MIN);
		size_sel  = (rel == REL_SIZE) ? word : tag_bytes_q;
		rnd       = {1'b0, size_sel} + 33'd7;
		adv       = {rnd[31:3], 3'b000};
		if (adv == 32'd0) begin
			adv = 32'd8;
		end
		next_off = {1'b0, tag_base_q} + {1'b0, adv};
		next_end = {1'b0, next_off} + 34'd8;
		adv_wrap = next_end > 34'h0_FFFF_FFFF;
		adv_exh  = next_end > {2'b00, total_q};
		fmt_ok   = (cap_addr_q != 64'd0) && (cap_width_q != 32'd0)
			&& (cap_height_q != 32'd0) && (word[7:0] == WANT_BPP)
			&& (word[15:8] == WANT_KIND);
	end

	always_comb begin
		byte_pos_d   = byte_pos_q;
		total_d      = total_q;
		tag_base_d   = tag_base_q;
		tag_kind_d   = tag_kind_q;
		tag_bytes_d  = tag_bytes_q;
		cap_addr_d   = cap_addr_q;
		cap_pitch_d  = cap_pitch_q;
		cap_width_d  = cap_width_q;
		cap_height_d = cap_height_q;
		cap_bpp_d    = cap_bpp_q;
		cap_kind_d   = cap_kind_q;
		scan_over_d  = scan_over_q;
		res_valid    = 1'b0;
		res.status   = ST_ACCEPT;
		do_adv       = 1'b0;

		if (fire && first_word) begin
			byte_pos_d   = 32'd4;
			total_d      = word;
			tag_base_d   = FIRST_TAG_OFF;
			tag_kind_d   = 32'd0;
			tag_bytes_d  = 32'd0;
			cap_addr_d   = 64'd0;
			cap_pitch_d  = 32'd0;
			cap_width_d  = 32'd0;
			cap_height_d = 32'd0;
			cap_bpp_d    = 8'd0;
			cap_kind_d   = 8'd0;
			scan_over_d  = 1'b0;
			// first tag at 8 cannot wrap; too small a total ends here
			if (word < MIN_TOTAL) begin
				res_valid   = 1'b1;
				res.status  = ST_EXHAUST;
				scan_over_d = 1'b1;
			end
		end else if (fire && !scan_over_q) begin
			byte_pos_d = byte_pos_q + 32'd4;
			case (rel)
				REL_KIND: begin
					tag_kind_d  = word;
					tag_bytes_d = 32'd0;
					if (word == END_TAG_TYPE) begin
						res_valid   = 1'b1;
						res.status  = ST_END;
						scan_over_d = 1'b1;
					end
				end
				REL_SIZE: begin
					tag_bytes_d = word;
					if (!((tag_kind_q == FB_TAG_TYPE) && (word >= FB_TAG_MIN))) begin
						do_adv = 1'b1;
					end
				end
				REL_ADDR_L: begin
					if (capturing) begin
						cap_addr_d[31:0] = word;
					end
				end
				REL_ADDR_H: begin
					if (capturing) begin
						cap_addr_d[63:32] = word;
					end
				end
				REL_PITCH: begin
					if (capturing) begin
						cap_pitch_d = word;
					end
				end
				REL_WIDTH: begin
					if (capturing) begin
						cap_width_d = word;
					end
				end
				REL_HEIGHT: begin
					if (capturing) begin
						cap_height_d = word;
					end
				end
				REL_FORMAT: begin
					if (capturing) begin
						cap_bpp_d  = word[7:0];
						cap_kind_d = word[15:8];
						if (fmt_ok) begin
							res_valid   = 1'b1;
							res.status  = ST_ACCEPT;
							scan_over_d = 1'b1;
						end else begin
							do_adv = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase

			if (do_adv) begin
				if (adv_wrap) begin
					res_valid   = 1'b1;
					res.status  = ST_WRAP;
					scan_over_d = 1'b1;
				end else if (adv_exh) begin
					res_valid   = 1'b1;
					res.status  = ST_EXHAUST;
					scan_over_d = 1'b1;
				end else begin
					tag_base_d = next_off[31:0];
				end
			end
		end

		res.fb_addr   = cap_addr_d;
		res.fb_pitch  = cap_pitch_d;
		res.fb_width  = cap_width_d;
		res.fb_height = cap_height_d;
		res.fb_bpp    = cap_bpp_d;
		res.fb_kind   = cap_kind_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q   <= 32'd0;
			total_q      <= 32'd0;
			tag_base_q   <= FIRST_TAG_OFF;
			tag_kind_q   <= 32'd0;
			tag_bytes_q  <= 32'd0;
			cap_addr_q   <= 64'd0;
			cap_pitch_q  <= 32'd0;
			cap_width_q  <= 32'd0;
			cap_height_q <= 32'd0;
			cap_bpp_q    <= 8'd0;
			cap_kind_q   <= 8'd0;
			scan_over_q  <= 1'b1;
		end else begin
			byte_pos_q   <= byte_pos_d;
			total_q      <= total_d;
			tag_base_q   <= tag_base_d;
			tag_kind_q   <= tag_kind_d;
			tag_bytes_q  <= tag_bytes_d;
			cap_addr_q   <= cap_addr_d;
			cap_pitch_q  <= cap_pitch_d;
			cap_width_q  <= cap_width_d;
			cap_height_q <= cap_height_d;
			cap_bpp_q    <= cap_bpp_d;
			cap_kind_q   <= cap_kind_d;
			scan_over_q  <= scan_over_d;
		end
	end

endmodule

`default_nettype wire
